### hw/rtl/uu8_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UCS-2/UCS-4 to UTF-8 converter.
// No dependencies.
package uu8_pkg;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   localparam int unsigned MaxBytes = 6;

   localparam logic [7:0] CONT_MARK = 8'h80;
   localparam logic [7:0] LEAD_2    = 8'hc0;
   localparam logic [7:0] LEAD_3    = 8'he0;
   localparam logic [7:0] LEAD_4    = 8'hf0;
   localparam logic [7:0] LEAD_5    = 8'hf8;
   localparam logic [7:0] LEAD_6    = 8'hfc;

   // One encoded code value: byte count and bytes, lead byte at index 0.
   typedef struct packed {
      logic [2:0]                  count;
      logic [MaxBytes-1:0][7:0]    bytes;
   } enc_type;

endpackage

### hw/rtl/uu8_encoder.sv
`timescale 1ns / 1ps
// Shortest UTF-8 form (31-bit variant) of one code value, 1 to 6 bytes.
// Depends on uu8_pkg.
module uu8_encoder (
   input  logic [30:0]          code,
   output uu8_pkg::enc_type     enc
);

   logic [5:0] s0, s1, s2, s3, s4;

   assign s0 = code[5:0];
   assign s1 = code[11:6];
   assign s2 = code[17:12];
   assign s3 = code[23:18];
   assign s4 = code[29:24];

   always_comb begin
      enc.bytes = '0;
      if (code[30:7] == 24'd0) begin
         enc.count    = 3'd1;
         enc.bytes[0] = {1'b0, code[6:0]};
      end else if (code[30:11] == 20'd0) begin
         enc.count    = 3'd2;
         enc.bytes[0] = uu8_pkg::LEAD_2 | {3'd0, code[10:6]};
         enc.bytes[1] = uu8_pkg::CONT_MARK | {2'd0, s0};
      end else if (code[30:16] == 15'd0) begin
         enc.count    = 3'd3;
         enc.bytes[0] = uu8_pkg::LEAD_3 | {4'd0, code[15:12]};
         enc.bytes[1] = uu8_pkg::CONT_MARK | {2'd0, s1};
         enc.bytes[2] = uu8_pkg::CONT_MARK | {2'd0, s0};
      end else if (code[30:21] == 10'd0) begin
         enc.count    = 3'd4;
         enc.bytes[0] = uu8_pkg::LEAD_4 | {5'd0, code[20:18]};
         enc.bytes[1] = uu8_pkg::CONT_MARK | {2'd0, s2};
         enc.bytes[2] = uu8_pkg::CONT_MARK | {2'd0, s1};
         enc.bytes[3] = uu8_pkg::CONT_MARK | {2'd0, s0};
      end else if (code[30:26] == 5'd0) begin
         enc.count    = 3'd5;
         enc.bytes[0] = uu8_pkg::LEAD_5 | {6'd0, code[25:24]};
         enc.bytes[1] = uu8_pkg::CONT_MARK | {2'd0, s3};
         enc.bytes[2] = uu8_pkg::CONT_MARK | {2'd0, s2};
         enc.bytes[3] = uu8_pkg::CONT_MARK | {2'd0, s1};
         enc.bytes[4] = uu8_pkg::CONT_MARK | {2'd0, s0};
      end else begin
         enc.count    = 3'd6;
         enc.bytes[0] = uu8_pkg::LEAD_6 | {7'd0, code[30]};
         enc.bytes[1] = uu8_pkg::CONT_MARK | {2'd0, s4};
         enc.bytes[2] = uu8_pkg::CONT_MARK | {2'd0, s3};
         enc.bytes[3] = uu8_pkg::CONT_MARK | {2'd0, s2};
         enc.bytes[4] = uu8_pkg::CONT_MARK | {2'd0, s1};
         enc.bytes[5] = uu8_pkg::CONT_MARK | {2'd0, s0};
      end
   end

endmodule

### hw/rtl/ucs_to_utf8_converter.sv
`timescale 1ns / 1ps
// Input bytes are held in the item register; results are offered from the run register.
// Throughput: one input transaction per cycle while each yields at most one
// result and the result port does not stall; otherwise the one-byte result
// port holds the input while it drains the run register of an item of n results (1..6).
// Reset (synchronous): clears gathering, error latch, pipeline; format = UCS-2.
// Depends on uu8_pkg and uu8_encoder.
module ucs_to_utf8_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_end,
   output logic [1:0]  rsp_status,
   output logic        rsp_string_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_source_format
);

   logic                 fmt_ff;
   logic [1:0]           gathered_ff, gathered_in;
   logic [23:0]          acc_ff, acc_in;
   logic                 err_ff, err_in;

   logic                 item_valid_ff, item_valid_in;
   logic [7:0]           item_byte_ff;
   logic                 item_last_ff;

   logic                 run_valid_ff, run_valid_in;
   logic [2:0]           run_index_ff, run_index_in;
   logic [2:0]           run_count_ff;
   uu8_pkg::status_type  run_status_ff;
   logic                 run_last_ff;
   logic [5:0][7:0]      run_bytes_ff;

   logic                 req_take, rsp_take, run_done, item_move, process;
   logic                 complete, load;
   logic [31:0]          code;
   uu8_pkg::enc_type     enc_out, new_enc;
   uu8_pkg::status_type  new_status;
   logic                 new_last;

   assign csr_ready = 1'b1;

   assign rsp_take  = run_valid_ff && !rsp_stall;
   assign rsp_run_end = (run_index_ff == run_count_ff - 3'd1);
   assign run_done  = rsp_take && rsp_run_end;
   assign item_move = !run_valid_ff || run_done;
   assign process   = item_valid_ff && item_move;
   assign req_stall = item_valid_ff && !item_move;
   assign req_take  = req_valid && !req_stall;

   assign complete = fmt_ff ? (gathered_ff == 2'd3) : (gathered_ff != 2'd0);
   assign code = fmt_ff ? {acc_ff, item_byte_ff} : {16'd0, acc_ff[7:0], item_byte_ff};

   uu8_encoder u_encoder (
      .code (code[30:0]),
      .enc  (enc_out)
   );

   always_comb begin
      gathered_in = gathered_ff;
      acc_in      = acc_ff;
      err_in      = err_ff;
      load        = 1'b0;
      new_status  = uu8_pkg::STATUS_OK;
      new_last    = item_last_ff;
      new_enc     = enc_out;
      if (process) begin
         if (err_ff) begin
            if (item_last_ff) begin
               err_in      = 1'b0;
               gathered_in = 2'd0;
               acc_in      = '0;
            end
         end else if (!complete) begin
            if (item_last_ff) begin
               gathered_in   = 2'd0;
               acc_in        = '0;
               load          = 1'b1;
               new_status    = uu8_pkg::STATUS_TRUNCATED;
               new_last      = 1'b1;
               new_enc.count = 3'd1;
               new_enc.bytes = '0;
            end else begin
               acc_in      = {acc_ff[15:0], item_byte_ff};
               gathered_in = gathered_ff + 2'd1;
            end
         end else begin
            gathered_in = 2'd0;
            acc_in      = '0;
            load        = 1'b1;
            if (code[31]) begin
               err_in        = !item_last_ff;
               new_status    = uu8_pkg::STATUS_RANGE;
               new_enc.count = 3'd1;
               new_enc.bytes = '0;
            end
         end
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (process) begin
         item_valid_in = 1'b0;
      end
      run_valid_in = run_valid_ff;
      run_index_in = run_index_ff;
      if (load) begin
         run_valid_in = 1'b1;
         run_index_in = 3'd0;
      end else if (run_done) begin
         run_valid_in = 1'b0;
      end else if (rsp_take) begin
         run_index_in = run_index_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff        <= 1'b0;
         gathered_ff   <= 2'd0;
         acc_ff        <= '0;
         err_ff        <= 1'b0;
         item_valid_ff <= 1'b0;
         run_valid_ff  <= 1'b0;
         run_index_ff  <= 3'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            fmt_ff <= csr_source_format;
         end
         gathered_ff   <= gathered_in;
         acc_ff        <= acc_in;
         err_ff        <= err_in;
         item_valid_ff <= item_valid_in;
         run_valid_ff  <= run_valid_in;
         run_index_ff  <= run_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_byte_ff <= req_in_byte;
         item_last_ff <= req_last_byte;
      end
      if (load) begin
         run_count_ff  <= new_enc.count;
         run_bytes_ff  <= new_enc.bytes;
         run_status_ff <= new_status;
         run_last_ff   <= new_last;
      end
   end

   assign rsp_valid      = run_valid_ff;
   assign rsp_out_byte   = run_bytes_ff[run_index_ff];
   assign rsp_status     = run_status_ff;
   assign rsp_string_end = rsp_run_end && run_last_ff;

`ifndef SYNTHESIS
   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> (run_index_ff < run_count_ff))
      else $error("run index beyond byte count");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (run_valid_ff && run_status_ff != uu8_pkg::STATUS_OK) |-> (run_count_ff == 3'd1))
      else $error("error run with more than one result");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid_ff && run_valid_ff))
      else $error("input stalled with no pending transaction");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !item_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
